@@ rtl/gbms_pkg.sv @@
// ----------------------------------------------------------------------------
// gbms_pkg
// Shared types and constants for the greedy binary model selection block.
// ----------------------------------------------------------------------------
package gbms_pkg;

    // Store geometry
    localparam int MAX_MODELS = 32;
    localparam int IDX_W      = $clog2(MAX_MODELS);
    localparam int ADDR_W     = 2 * IDX_W;

    // Field widths
    localparam int WEIGHT_W = 32;
    localparam int GAIN_W   = 40;
    localparam int CNT_W    = 6;

    // Register reset value
    localparam logic [CNT_W-1:0] MODEL_COUNT_RESET = CNT_W'(32);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input item
    typedef struct packed {
        logic [4:0]                 row;
        logic [4:0]                 col;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last_entry;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [4:0] model_index;
        logic       selected;
        logic       last_result;
    } result_t;

    // Command kinds: every command stores; a solve command then runs the search
    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_SOLVE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [ADDR_W-1:0]   addr;
        logic [WEIGHT_W-1:0] weight;
    } cmd_t;

endpackage

@@ rtl/gbms_front.sv @@
// ----------------------------------------------------------------------------
// gbms_front
// Input stage: takes matrix entries, classifies them into store or solve
// commands with a flat store address, and holds one command in a register.
// ----------------------------------------------------------------------------
module gbms_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gbms_pkg::in_item_t in_data,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output gbms_pkg::cmd_t     cmd_data
);

    logic           cmd_valid_reg;
    gbms_pkg::cmd_t cmd_data_reg;
    gbms_pkg::cmd_t cmd_next;

    // Classify: the flagged entry starts a solve, row-major address
    always_comb
    begin
        cmd_next.kind   = in_data.last_entry ? gbms_pkg::CMD_SOLVE : gbms_pkg::CMD_STORE;
        cmd_next.addr   = {in_data.row, in_data.col};
        cmd_next.weight = in_data.weight;
    end

    assign in_ready = !cmd_valid_reg || cmd_ready;

    // Command register, refilled on every transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            cmd_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_data_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_data  = cmd_data_reg;

endmodule

@@ rtl/gbms_queue.sv @@
// ----------------------------------------------------------------------------
// gbms_queue
// Short command FIFO that decouples the input stage from the solver.
// ----------------------------------------------------------------------------
module gbms_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  gbms_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output gbms_pkg::cmd_t pop_data
);

    gbms_pkg::cmd_t                slot_reg [gbms_pkg::QUEUE_DEPTH];
    logic [gbms_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [gbms_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [gbms_pkg::QCNT_W-1:0]   count_reg;
    logic                          push;
    logic                          pop;

    assign push_ready = (count_reg != gbms_pkg::QCNT_W'(gbms_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Fill count agrees with the pointer distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != gbms_pkg::QCNT_W'(gbms_pkg::QUEUE_DEPTH)) |->
        (gbms_pkg::QPTR_W'(wr_ptr_reg - rd_ptr_reg) == gbms_pkg::QPTR_W'(count_reg)))
        else $error("queue count does not match pointers");

endmodule

@@ rtl/gbms_back.sv @@
// ----------------------------------------------------------------------------
// gbms_back
// Solver: writes the weight store, runs the greedy rounds over a gain
// register file (one entry per cycle), and emits one result per model.
// ----------------------------------------------------------------------------
module gbms_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  gbms_pkg::cmd_t                q_data,
    input  logic [gbms_pkg::CNT_W-1:0]    model_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gbms_pkg::result_t             out_data
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Weight store and read ports
    logic [gbms_pkg::WEIGHT_W-1:0] mem [gbms_pkg::MAX_MODELS * gbms_pkg::MAX_MODELS];
    logic [gbms_pkg::WEIGHT_W-1:0] rd_a_reg;
    logic [gbms_pkg::WEIGHT_W-1:0] rd_b_reg;
    logic [gbms_pkg::ADDR_W-1:0]   rd_addr_a;
    logic [gbms_pkg::ADDR_W-1:0]   rd_addr_b;
    logic                          mem_we;

    // Sequencer
    state_t                        state_reg;
    logic [gbms_pkg::IDX_W-1:0]    n_last_reg;
    logic [gbms_pkg::IDX_W-1:0]    n_last_next;
    logic [gbms_pkg::IDX_W-1:0]    idx_reg;
    logic [gbms_pkg::IDX_W-1:0]    pick_reg;
    logic                          upd_reg;
    logic [gbms_pkg::MAX_MODELS-1:0] mask_reg;

    // Gain file and pipeline
    logic signed [gbms_pkg::GAIN_W-1:0] gain_reg [gbms_pkg::MAX_MODELS];
    logic                               p1_valid_reg;
    logic                               p1_elig_reg;
    logic                               p1_upd_reg;
    logic [gbms_pkg::IDX_W-1:0]         p1_idx_reg;
    logic signed [gbms_pkg::GAIN_W-1:0] ext_a;
    logic signed [gbms_pkg::GAIN_W-1:0] ext_b;
    logic signed [gbms_pkg::GAIN_W-1:0] gain_sum;
    logic                               cand_valid_reg;
    logic signed [gbms_pkg::GAIN_W-1:0] cand_gain_reg;
    logic [gbms_pkg::IDX_W-1:0]         cand_idx_reg;

    // Running best of the current round
    logic                               found_reg;
    logic signed [gbms_pkg::GAIN_W-1:0] best_gain_reg;
    logic [gbms_pkg::IDX_W-1:0]         best_idx_reg;
    logic                               best_pos;
    logic                               drained;

    // Output register
    logic                               out_valid_reg;
    gbms_pkg::result_t                  out_data_reg;

    assign q_ready = (state_reg == ST_LOAD);
    assign mem_we  = q_valid && q_ready;

    // Models in use minus one: zero counts as one, saturate at store size
    always_comb
    begin
        if (model_count == '0)
        begin
            n_last_next = '0;
        end
        else if (model_count > gbms_pkg::CNT_W'(gbms_pkg::MAX_MODELS))
        begin
            n_last_next = gbms_pkg::IDX_W'(gbms_pkg::MAX_MODELS - 1);
        end
        else
        begin
            n_last_next = gbms_pkg::IDX_W'(model_count - 1'b1);
        end
    end

    // Diagonal pass reads Q[i][i]; update pass reads Q[i][b] and Q[b][i]
    assign rd_addr_a = upd_reg ? {idx_reg, pick_reg} : {idx_reg, idx_reg};
    assign rd_addr_b = {pick_reg, idx_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_data.addr] <= q_data.weight;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // New gain for the entry in stage 1
    assign ext_a    = {{(gbms_pkg::GAIN_W - gbms_pkg::WEIGHT_W){rd_a_reg[gbms_pkg::WEIGHT_W-1]}},
                       rd_a_reg};
    assign ext_b    = {{(gbms_pkg::GAIN_W - gbms_pkg::WEIGHT_W){rd_b_reg[gbms_pkg::WEIGHT_W-1]}},
                       rd_b_reg};
    assign gain_sum = p1_upd_reg ? (gain_reg[p1_idx_reg] + ext_a + ext_b) : ext_a;

    // Gain file and candidate register
    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            gain_reg[p1_idx_reg] <= gain_sum;
        end
        cand_gain_reg <= gain_sum;
        cand_idx_reg  <= p1_idx_reg;
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg   <= 1'b0;
            p1_elig_reg    <= 1'b0;
            p1_upd_reg     <= 1'b0;
            p1_idx_reg     <= '0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg   <= (state_reg == ST_SCAN);
            p1_elig_reg    <= !mask_reg[idx_reg];
            p1_upd_reg     <= upd_reg;
            p1_idx_reg     <= idx_reg;
            cand_valid_reg <= p1_valid_reg && p1_elig_reg;
        end
    end

    assign best_pos = !best_gain_reg[gbms_pkg::GAIN_W-1] && (best_gain_reg != '0);
    assign drained  = !p1_valid_reg && !cand_valid_reg;

    // Sequencer, best tracking and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            n_last_reg    <= '0;
            idx_reg       <= '0;
            pick_reg      <= '0;
            upd_reg       <= 1'b0;
            mask_reg      <= '0;
            found_reg     <= 1'b0;
            best_gain_reg <= '0;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // strict compare keeps the lowest index on ties
            if (cand_valid_reg && (!found_reg || (cand_gain_reg > best_gain_reg)))
            begin
                found_reg     <= 1'b1;
                best_gain_reg <= cand_gain_reg;
                best_idx_reg  <= cand_idx_reg;
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (q_valid && (q_data.kind == gbms_pkg::CMD_SOLVE))
                    begin
                        n_last_reg <= n_last_next;
                        idx_reg    <= '0;
                        upd_reg    <= 1'b0;
                        mask_reg   <= '0;
                        found_reg  <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg == n_last_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (drained)
                    begin
                        idx_reg <= '0;
                        if (found_reg && best_pos)
                        begin
                            mask_reg  <= mask_reg |
                                         (gbms_pkg::MAX_MODELS'(1) << best_idx_reg);
                            pick_reg  <= best_idx_reg;
                            upd_reg   <= 1'b1;
                            found_reg <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.model_index  <= idx_reg;
                        out_data_reg.selected     <= mask_reg[idx_reg];
                        out_data_reg.last_result  <= (idx_reg == n_last_reg);
                        if (idx_reg == n_last_reg)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A round never picks a model that is already selected
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN) && drained && found_reg) |-> !mask_reg[best_idx_reg])
        else $error("greedy round picked a selected model");

    // Stage 1 only carries entries issued by the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> $past(state_reg == ST_SCAN))
        else $error("pipeline valid without scan issue");

    // Never more selected models than models in use
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(mask_reg) <= ({1'b0, n_last_reg} + 1)))
        else $error("selection exceeds models in use");

    // Emission starts only after the pipeline has drained
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)) |=> !$rose(state_reg == ST_EMIT) ||
        $past(drained))
        else $error("emission started before the pipeline drained");

endmodule

@@ rtl/greedy_binary_model_select_top.sv @@
// ----------------------------------------------------------------------------
// greedy_binary_model_select_top
// Loads a signed Q16.16 weight matrix entry by entry and, on the flagged last
// entry, runs a greedy 0/1 maximization of m'Qm and reports one bit per model.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid / in_ready   | row, col, weight, last_entry
//  out     | output    | out_valid / out_ready | model_index, selected, last_result
//  cfg     | input     | cfg_valid / cfg_ready | model_count (6 bits)
//
//  Entries load at one per cycle through a register stage and a 4-deep queue.
//  A solve over n models runs a diagonal scan round and then an update round for
//  each selected model, with one gain update per cycle from the two-read-port
//  weight store, then emits n results; input transfers stall once the queue fills.
//  Reset clears control state and sets model_count to 32; the weight store is
//  not cleared and must be written before it is used.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module greedy_binary_model_select_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  gbms_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output gbms_pkg::result_t          out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [gbms_pkg::CNT_W-1:0] cfg_data
);

    logic                       cmd_valid;
    logic                       cmd_ready;
    gbms_pkg::cmd_t             cmd_data;
    logic                       q_valid;
    logic                       q_ready;
    gbms_pkg::cmd_t             q_data;
    logic [gbms_pkg::CNT_W-1:0] model_count_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_count_reg <= gbms_pkg::MODEL_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            model_count_reg <= cfg_data;
        end
    end

    gbms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    gbms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_data  (cmd_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    gbms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data),
        .model_count (model_count_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
